@@ hdl/three_stacks_shared_buffer_top_defines.svh @@
// Assertion macros for the block's RTL.
`ifndef THREE_STACKS_SHARED_BUFFER_TOP_DEFINES_SVH
`define THREE_STACKS_SHARED_BUFFER_TOP_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define TSS_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("tss: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tss: implication violated");

`endif

@@ hdl/tss_pkg.sv @@
`default_nettype none

package tss_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int DATA_BITS     = 32;
	localparam int DEP_BITS      = 5;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [1:0] SEL_LOWER  = 2'd0;
	localparam logic [1:0] SEL_MIDDLE = 2'd1;
	localparam logic [1:0] SEL_UPPER  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                 action;
		logic [1:0]           stack_select;
		logic [DATA_BITS-1:0] push_value;
	} tss_req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] pop_value;
		status_t              status;
		logic [DEP_BITS-1:0]  depth_after;
	} tss_res_t;

endpackage

`default_nettype wire

@@ hdl/three_stacks_shared_buffer_top.sv @@
// Three stacks in one shared buffer of DEPTH words.
// Input channel (in_valid/in_ready): one beat is a push or pop on the
// lower, middle or upper stack. Output channel (out_valid/out_ready): one
// beat per input beat, carrying pop_value, status and depth_after.
// in_ready is high only while the sequencer is idle; it drops for the
// whole of an item's processing.
// Each item: a pop, or a push with a free entry beside the target stack,
// passes S_POP or S_WRITE and then S_RESP; an error reply goes straight
// to S_RESP. A push with no neighboring free entry first slides the
// middle stack one entry through the word memory, one word per cycle.
// out_valid is registered from the engine's S_RESP result. A result held
// by a stalled receiver sits in the output register; the next beat is
// still accepted and processed, and its result waits in S_RESP until the
// register frees up.
// Reset clears the stack counts and places the middle base at DEPTH/3.
// Word memory contents are not cleared.
`default_nettype none

module three_stacks_shared_buffer_top #(
	parameter int DEPTH     = tss_pkg::DEPTH_DEF,
	parameter int WORD_BITS = tss_pkg::WORD_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                action,
	input  wire logic [1:0]                          stack_select,
	input  wire logic signed [tss_pkg::DATA_BITS-1:0] push_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [tss_pkg::DATA_BITS-1:0]      pop_value,
	output tss_pkg::status_t                          status,
	output logic [tss_pkg::DEP_BITS-1:0]             depth_after
);
	import tss_pkg::*;

	tss_req_t req;
	tss_res_t res;
	logic     res_valid;
	logic     res_ready;
	logic     out_valid_q;
	tss_res_t out_q;

	assign req.action       = action;
	assign req.stack_select = stack_select;
	assign req.push_value   = push_value;

	tss_engine #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign pop_value   = out_q.pop_value;
	assign status      = out_q.status;
	assign depth_after = out_q.depth_after;

endmodule

`default_nettype wire

@@ hdl/tss_engine.sv @@
`default_nettype none

`include "three_stacks_shared_buffer_top_defines.svh"

module tss_engine #(
	parameter int DEPTH     = tss_pkg::DEPTH_DEF,
	parameter int WORD_BITS = tss_pkg::WORD_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire tss_pkg::tss_req_t req,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output tss_pkg::tss_res_t     res
);
	import tss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 2;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_WRITE, S_POP, S_RESP} state_t;

	state_t               state_q;
	logic [CW-1:0]        lower_q;
	logic [CW-1:0]        middle_q;
	logic [CW-1:0]        upper_q;
	logic [CW-1:0]        base_q;
	logic [1:0]           sel_q;
	logic [WORD_BITS-1:0] val_q;
	logic                 shift_up_q;
	logic [CW-1:0]        rem_q;
	logic [AW-1:0]        src_q;
	logic                 pend_q;
	logic [AW-1:0]        dst_q;
	status_t              status_q;
	logic [CW-1:0]        dep_q;
	logic                 pop_ok_q;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 re;
	logic                 we;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;

	logic [SW-1:0]        mid_top;
	logic [SW-1:0]        mid_dec;
	logic [SW-1:0]        used_above;
	logic [SW-1:0]        total;
	logic [SW-1:0]        up_free;
	logic [SW-1:0]        up_push;
	logic [CW-1:0]        lower_dec;
	logic                 is_full;
	logic                 gap_above;
	logic                 gap_below;
	logic [CW-1:0]        req_cnt;
	logic [CW-1:0]        cur_cnt;
	logic [AW-1:0]        push_addr;
	logic [AW-1:0]        pop_addr;
	logic [DATA_BITS-1:0] pop_word;

	assign mid_top    = SW'(base_q) + SW'(middle_q);
	assign mid_dec    = mid_top - SW'(1);
	assign used_above = mid_top + SW'(upper_q);
	assign total      = SW'(lower_q) + SW'(middle_q) + SW'(upper_q);
	assign up_free    = DEPTH_S - SW'(upper_q);
	assign up_push    = up_free - SW'(1);
	assign lower_dec  = lower_q - CW'(1);
	assign is_full    = total >= DEPTH_S;
	assign gap_above  = used_above < DEPTH_S;
	assign gap_below  = lower_q < base_q;

	always_comb begin
		unique case (req.stack_select)
			SEL_LOWER:  req_cnt = lower_q;
			SEL_MIDDLE: req_cnt = middle_q;
			default:    req_cnt = upper_q;
		endcase
	end

	always_comb begin
		unique case (sel_q)
			SEL_LOWER: begin
				cur_cnt   = lower_q;
				push_addr = lower_q[AW-1:0];
				pop_addr  = lower_dec[AW-1:0];
			end
			SEL_MIDDLE: begin
				cur_cnt   = middle_q;
				push_addr = mid_top[AW-1:0];
				pop_addr  = mid_dec[AW-1:0];
			end
			default: begin
				cur_cnt   = upper_q;
				push_addr = up_push[AW-1:0];
				pop_addr  = up_free[AW-1:0];
			end
		endcase
	end

	// memory port control
	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		raddr = src_q;
		waddr = dst_q;
		wdata = rdata_q;
		unique case (state_q)
			S_SHIFT: begin
				re = (rem_q != '0);
				we = pend_q;
			end
			S_WRITE: begin
				we    = 1'b1;
				waddr = push_addr;
				wdata = val_q;
			end
			S_POP: begin
				re    = 1'b1;
				raddr = pop_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lower_q    <= '0;
			middle_q   <= '0;
			upper_q    <= '0;
			base_q     <= CW'(DEPTH / 3);
			sel_q      <= SEL_LOWER;
			val_q      <= '0;
			shift_up_q <= 1'b0;
			rem_q      <= '0;
			src_q      <= '0;
			pend_q     <= 1'b0;
			dst_q      <= '0;
			status_q   <= ST_OK;
			dep_q      <= '0;
			pop_ok_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						sel_q    <= req.stack_select;
						val_q    <= WORD_BITS'(req.push_value);
						status_q <= ST_OK;
						dep_q    <= '0;
						pop_ok_q <= 1'b0;
						pend_q   <= 1'b0;
						rem_q    <= middle_q;
						priority if (req.stack_select != SEL_LOWER &&
							req.stack_select != SEL_MIDDLE &&
							req.stack_select != SEL_UPPER) begin
							status_q <= (req.action == ACT_POP) ? ST_EMPTY : ST_FULL;
							state_q  <= S_RESP;
						end else if (req.action == ACT_PUSH) begin
							priority if (is_full) begin
								status_q <= ST_FULL;
								dep_q    <= req_cnt;
								state_q  <= S_RESP;
							end else if (req.stack_select == SEL_LOWER && !gap_below) begin
								shift_up_q <= 1'b1;
								src_q      <= mid_dec[AW-1:0];
								state_q    <= S_SHIFT;
							end else if (req.stack_select != SEL_LOWER && !gap_above) begin
								shift_up_q <= 1'b0;
								src_q      <= base_q[AW-1:0];
								state_q    <= S_SHIFT;
							end else begin
								state_q <= S_WRITE;
							end
						end else if (req_cnt == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_SHIFT: begin
					if (rem_q != '0) begin
						rem_q  <= rem_q - CW'(1);
						pend_q <= 1'b1;
						if (shift_up_q) begin
							src_q <= src_q - AW'(1);
							dst_q <= src_q + AW'(1);
						end else begin
							src_q <= src_q + AW'(1);
							dst_q <= src_q - AW'(1);
						end
					end else begin
						pend_q  <= 1'b0;
						base_q  <= shift_up_q ? base_q + CW'(1) : base_q - CW'(1);
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					unique case (sel_q)
						SEL_LOWER:  lower_q  <= lower_q + CW'(1);
						SEL_MIDDLE: middle_q <= middle_q + CW'(1);
						default:    upper_q  <= upper_q + CW'(1);
					endcase
					dep_q   <= cur_cnt + CW'(1);
					state_q <= S_RESP;
				end
				S_POP: begin
					unique case (sel_q)
						SEL_LOWER:  lower_q  <= lower_dec;
						SEL_MIDDLE: middle_q <= middle_q - CW'(1);
						default:    upper_q  <= upper_q - CW'(1);
					endcase
					dep_q    <= cur_cnt - CW'(1);
					pop_ok_q <= 1'b1;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	generate
		if (WORD_BITS >= DATA_BITS) begin : g_trunc
			assign pop_word = DATA_BITS'(rdata_q);
		end else begin : g_sext
			assign pop_word = DATA_BITS'(signed'(rdata_q));
		end
	endgenerate

	assign req_ready       = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_RESP);
	assign res.pop_value   = pop_ok_q ? pop_word : '0;
	assign res.status      = status_q;
	assign res.depth_after = DEP_BITS'(dep_q);

	`TSS_ASSERT(a_lower_under_base, clk, arst_n, lower_q <= base_q)
	`TSS_ASSERT(a_upper_fits, clk, arst_n, used_above <= DEPTH_S)
	`TSS_ASSERT_IMP(a_port_clash, clk, arst_n, we && re, waddr != raddr)

endmodule

`default_nettype wire
